/* rtl/alw_pkg.sv */
package alw_pkg;

    localparam logic [8:0] RATE_DIVIDEND = 9'd450;
    localparam logic [7:0] RELOAD_SAT    = 8'd255;

    localparam logic [1:0] REG_WARM_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_WARM_TICKS      = 2'd1;
    localparam logic [1:0] REG_INITIAL_SAMPLES = 2'd2;
    localparam logic [1:0] REG_INITIAL_WAIT    = 2'd3;

    typedef struct packed {
        logic [9:0] light_sample;
        logic [9:0] temp_sample;
    } sample_t;

    typedef struct packed {
        logic       log_valid;
        logic [6:0] log_position;
        logic [7:0] log_value;
        logic       rate_adjusted;
        logic       playback_start;
        logic [6:0] playback_position;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } alw_state_t;

    typedef struct packed {
        logic       start;
        logic [7:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] quotient;
    } div_sts_t;

endpackage

/* rtl/alw_div.sv */
module alw_div
    import alw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_ctl_t ctl,
    output div_sts_t sts
);

    logic [7:0] rem_reg, rem_next;
    logic [8:0] quo_reg, quo_next;
    logic [7:0] dvs_reg, dvs_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;

    logic [8:0] trial;
    logic [8:0] diff;
    logic       ge;

    // restoring divide, one quotient bit per cycle; dividend shifts out of quo_reg
    assign trial = {rem_reg, quo_reg[8]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next  = 8'd0;
            quo_next  = RATE_DIVIDEND;
            dvs_next  = ctl.divisor;
            cnt_next  = 4'd9;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[7:0] : trial[7:0];
            quo_next = {quo_reg[7:0], ge};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 4'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign sts.quotient = quo_reg[7:0];

endmodule

/* rtl/adaptive_light_logger_warm_detect.sv */
// channel   | valid         | stall         | payload
// ----------+---------------+---------------+-------------------
// sample in | sample_valid  | sample_stall  | sample  (sample_t)
// result out| result_valid  | result_stall  | result  (result_t)
// config    | psel/penable  | pready = 1    | paddr/pwdata/prdata
//
// A beat goes through ST_DONE, and first through ST_DIV when a sum wrap recomputes
// the wait reload (serial divide of 450 by the sample count in alw_div).
// sample_stall is high from acceptance until the result is loaded into the
// output register; a stalled result holds that register and delays the next beat.
// Reset clears the control state and loads the register defaults; result and divider data registers are not reset.
module adaptive_light_logger_warm_detect
    import alw_pkg::*;
#(
    parameter int RING_DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [6:0] RING_LAST = 7'(RING_DEPTH - 1);

    alw_state_t state_reg, state_next;

    logic [9:0]  warm_threshold_reg;
    logic [7:0]  warm_ticks_reg;
    logic [7:0]  initial_samples_reg;
    logic [7:0]  initial_wait_reg;

    logic [15:0] light_sum_reg, light_sum_next;
    logic [7:0]  samples_left_reg, samples_left_next;
    logic [7:0]  wait_left_reg, wait_left_next;
    logic [6:0]  ring_reg, ring_next;
    logic [7:0]  spv_reg, spv_next;
    logic [7:0]  reload_reg, reload_next;
    logic [9:0]  last_temp_reg, last_temp_next;
    logic [7:0]  rise_reg, rise_next;

    result_t     res_reg, res_next;
    result_t     out_reg;
    logic        out_valid_reg;

    div_ctl_t    div_ctl;
    div_sts_t    div_sts;

    logic        accept;
    logic        cfg_wr;
    logic        out_load;

    logic [16:0] sum_ext;
    logic        wrap;
    logic [7:0]  sl_eff;
    logic [9:0]  prev_temp;
    logic        drop;
    logic [7:0]  rise_cnt;
    logic        play;

    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite;
    assign sample_stall = state_reg != ST_IDLE;
    assign accept       = sample_valid && !sample_stall;
    assign out_load     = state_reg == ST_DONE && (!out_valid_reg || !result_stall);

    always_comb
    begin
        case (paddr[3:2])
            REG_WARM_THRESHOLD:  prdata = {22'd0, warm_threshold_reg};
            REG_WARM_TICKS:      prdata = {24'd0, warm_ticks_reg};
            REG_INITIAL_SAMPLES: prdata = {24'd0, initial_samples_reg};
            REG_INITIAL_WAIT:    prdata = {24'd0, initial_wait_reg};
            default:             prdata = 32'd0;
        endcase
    end

    alw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sts   (div_sts)
    );

    always_comb
    begin
        state_next        = state_reg;
        light_sum_next    = light_sum_reg;
        samples_left_next = samples_left_reg;
        wait_left_next    = wait_left_reg;
        ring_next         = ring_reg;
        spv_next          = spv_reg;
        reload_next       = reload_reg;
        last_temp_next    = last_temp_reg;
        rise_next         = rise_reg;
        res_next          = res_reg;
        div_ctl.start     = 1'b0;
        div_ctl.divisor   = 8'd0;

        sum_ext   = {1'b0, light_sum_reg} + {7'd0, sample.light_sample};
        wrap      = sum_ext[16];
        sl_eff    = samples_left_reg;
        prev_temp = (last_temp_reg == 10'd0) ? sample.temp_sample : last_temp_reg;
        drop      = prev_temp > sample.temp_sample
                    && (prev_temp - sample.temp_sample) > warm_threshold_reg;
        rise_cnt  = drop ? rise_reg + 8'd1 : 8'd0;
        play      = rise_cnt > warm_ticks_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                    if (wait_left_reg == 8'd0)
                    begin
                        light_sum_next = sum_ext[15:0];
                        if (wrap)
                        begin
                            // sum keeps its old value, count drops by what is outstanding plus one
                            spv_next       = spv_reg - samples_left_reg - 8'd1;
                            sl_eff         = 8'd0;
                            light_sum_next = light_sum_reg;
                            res_next.rate_adjusted = 1'b1;
                            if (spv_next == 8'd0)
                            begin
                                reload_next = RELOAD_SAT;
                            end
                            else
                            begin
                                div_ctl.start   = 1'b1;
                                div_ctl.divisor = spv_next;
                                state_next      = ST_DIV;
                            end
                        end
                        if (sl_eff == 8'd0)
                        begin
                            samples_left_next     = spv_next;
                            res_next.log_valid    = 1'b1;
                            res_next.log_position = ring_reg;
                            res_next.log_value    = light_sum_next[15:8];
                            light_sum_next        = 16'd0;
                            ring_next = (ring_reg >= RING_LAST) ? 7'd0 : ring_reg + 7'd1;
                        end
                        else
                        begin
                            samples_left_next = sl_eff - 8'd1;
                        end
                        wait_left_next = reload_next;
                    end
                    else
                    begin
                        wait_left_next = wait_left_reg - 8'd1;
                    end
                    rise_next                  = play ? 8'd0 : rise_cnt;
                    res_next.playback_start    = play;
                    res_next.playback_position = ring_next;
                    last_temp_next             = sample.temp_sample;
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    reload_next    = div_sts.quotient;
                    wait_left_next = div_sts.quotient;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr && paddr[3:2] == REG_INITIAL_SAMPLES)
        begin
            spv_next = pwdata[7:0];
        end
        if (cfg_wr && paddr[3:2] == REG_INITIAL_WAIT)
        begin
            reload_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            warm_threshold_reg  <= 10'd3;
            warm_ticks_reg      <= 8'd2;
            initial_samples_reg <= 8'd255;
            initial_wait_reg    <= 8'd8;
            light_sum_reg       <= 16'd0;
            samples_left_reg    <= 8'd0;
            wait_left_reg       <= 8'd0;
            ring_reg            <= 7'd0;
            spv_reg             <= 8'd255;
            reload_reg          <= 8'd8;
            last_temp_reg       <= 10'd0;
            rise_reg            <= 8'd0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            light_sum_reg    <= light_sum_next;
            samples_left_reg <= samples_left_next;
            wait_left_reg    <= wait_left_next;
            ring_reg         <= ring_next;
            spv_reg          <= spv_next;
            reload_reg       <= reload_next;
            last_temp_reg    <= last_temp_next;
            rise_reg         <= rise_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_WARM_THRESHOLD:  warm_threshold_reg  <= pwdata[9:0];
                    REG_WARM_TICKS:      warm_ticks_reg      <= pwdata[7:0];
                    REG_INITIAL_SAMPLES: initial_samples_reg <= pwdata[7:0];
                    REG_INITIAL_WAIT:    initial_wait_reg    <= pwdata[7:0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_ring_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_reg <= RING_LAST)
        else $error("ring position beyond ring depth");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.busy |-> state_reg == ST_DIV)
        else $error("divider running outside divide state");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a finished beat");

    a_div_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_sts.done) |=> state_reg == ST_DONE)
        else $error("divide finished but sequencer did not advance");
`endif

endmodule
